FILE: rtl/bsg_pkg.sv
package bsg_pkg;

	localparam int ELEM_BITS  = 12;
	localparam int POS_BITS   = 12;
	localparam int COND_WORDS = 736;
	localparam int CADDR_BITS = 10;
	localparam int LAYERS     = 23;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_RDATA,
		ST_NRD,
		ST_NW1,
		ST_NW2
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic init_we;
		logic load_we;
		logic rd_issue;
		logic out_load;
		logic net_w1;
		logic net_w2;
		logic set_done;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic init_last;
		logic count_last;
		logic net_last;
		logic done;
		logic out_busy;
	} status_t;

	// twelve-bit bit reversal
	function automatic logic [POS_BITS-1:0] rev12(input logic [POS_BITS-1:0] a);
		logic [POS_BITS-1:0] r;
		for (int i = 0; i < POS_BITS; i++)
			r[i] = a[POS_BITS-1-i];
		return r;
	endfunction

	// 1 when the layer uses transposed 4-byte condition groups
	function automatic logic layer_narrow(input logic [4:0] t);
		return (t < 5'd6) || (t > 5'd16);
	endfunction

	// log2 of the row distance of a layer
	function automatic logic [2:0] layer_lg(input logic [4:0] t);
		logic [4:0] v;
		if (t < 5'd6)
			v = t;
		else if (t < 5'd12)
			v = t - 5'd6;
		else if (t < 5'd17)
			v = 5'd16 - t;
		else
			v = 5'd22 - t;
		return v[2:0];
	endfunction

	// insert a zero bit at position lg of a 5-bit pair index
	function automatic logic [5:0] insert_zero(input logic [4:0] k, input logic [2:0] lg);
		logic [5:0] mask;
		logic [5:0] kk;
		mask = (6'd1 << lg) - 6'd1;
		kk   = {1'b0, k};
		return ((kk & ~mask) << 1) | (kk & mask);
	endfunction

endpackage

FILE: rtl/bsg_in_if.sv
interface bsg_in_if;
	import bsg_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  mode;
	logic [63:0]           cond_word;
	logic [POS_BITS-1:0]   read_index;

	modport source (output valid, mode, cond_word, read_index, input ready);
	modport sink   (input valid, mode, cond_word, read_index, output ready);
endinterface

FILE: rtl/bsg_out_if.sv
interface bsg_out_if;
	import bsg_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [ELEM_BITS-1:0]  support_elem;
	logic                  valid_res;

	modport source (output valid, support_elem, valid_res, input ready);
	modport sink   (input valid, support_elem, valid_res, output ready);
endinterface

FILE: rtl/benes_support_generation.sv
// Support generator: after reset the element store is filled with the bit-reversed
// index of each of its 4096 positions, one per cycle, and no transaction is taken
// during that sweep. A mode 0 transaction stores the next 64-bit condition word
// and gives no result, so loads can follow back to back; the 736th word starts
// the 23-layer Benes network, which runs as 23 x 2048 compare-and-swap steps, each
// a read state and two write states (set by the single write port of the element
// store), while input is held off. Further words after that are dropped. A mode 1
// transaction reads one element from the store into the result register during
// ST_RDATA and presents it from there; input is held off while the result register
// is full, so a read is not taken until the previous result has been accepted.
// valid_res is 0 and the element 0 when the network has not finished or the index
// is at or above SUPPORT_COUNT.
module benes_support_generation
	import bsg_pkg::*;
#(
	parameter int SUPPORT_COUNT = 3488
) (
	input  logic  clk,
	input  logic  arst_n,
	bsg_in_if.sink    in_ch,
	bsg_out_if.source out_ch
);
	cmd_t    cmd;
	status_t st;

	// sequencer: init sweep, idle, read return and network steps
	bsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_mode  (in_ch.mode),
		.in_ready (in_ch.ready),
		.st       (st),
		.cmd      (cmd)
	);

	// stores, counters, swap addressing and the output register
	bsg_datapath #(.SUPPORT_COUNT(SUPPORT_COUNT)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.cond_word    (in_ch.cond_word),
		.read_index   (in_ch.read_index),
		.out_ready    (out_ch.ready),
		.out_valid    (out_ch.valid),
		.support_elem (out_ch.support_elem),
		.valid_res    (out_ch.valid_res)
	);
endmodule

FILE: rtl/bsg_ram.sv
module bsg_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end
endmodule

FILE: rtl/bsg_ctrl.sv
module bsg_ctrl
	import bsg_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_mode,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);
	state_t state_q, state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE) && !st.out_busy;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_INIT;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (st.init_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept && in_mode)
					state_d = ST_RDATA;
				else if (accept && !st.done && st.count_last)
					state_d = ST_NRD;
			end
			ST_RDATA: state_d = ST_IDLE;
			ST_NRD:   state_d = ST_NW1;
			ST_NW1:   state_d = ST_NW2;
			ST_NW2: begin
				state_d = st.net_last ? ST_IDLE : ST_NRD;
			end
			default:  state_d = ST_INIT;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.init_we  = (state_q == ST_INIT);
		cmd.load_we  = accept && !in_mode && !st.done;
		cmd.rd_issue = accept && in_mode;
		cmd.out_load = (state_q == ST_RDATA);
		cmd.net_w1   = (state_q == ST_NW1);
		cmd.net_w2   = (state_q == ST_NW2);
		cmd.set_done = (state_q == ST_NW2) && st.net_last;
	end
endmodule

FILE: rtl/bsg_datapath.sv
module bsg_datapath
	import bsg_pkg::*;
#(
	parameter int SUPPORT_COUNT = 3488
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output status_t              st,
	input  logic [63:0]          cond_word,
	input  logic [POS_BITS-1:0]  read_index,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [ELEM_BITS-1:0] support_elem,
	output logic                 valid_res
);
	localparam logic [POS_BITS:0] SUP_LIMIT = (POS_BITS+1)'(SUPPORT_COUNT);

	logic [POS_BITS-1:0]   init_cnt_q;
	logic [CADDR_BITS-1:0] word_cnt_q;
	logic [4:0]            layer_q;
	logic [10:0]           pair_q;
	logic                  done_q;
	logic                  ok_s1;
	logic                  out_valid_q;
	logic [ELEM_BITS-1:0]  elem_q;
	logic                  vres_q;

	logic                  narrow;
	logic [2:0]            lg;
	logic [4:0]            k;
	logic [5:0]            x, y0, y1;
	logic [POS_BITS-1:0]   addr_a, addr_b;
	logic [CADDR_BITS-1:0] cond_addr;
	logic [5:0]            cbit;
	logic [63:0]           cond_rdata;
	logic [ELEM_BITS-1:0]  rdata0, rdata1;
	logic                  swap;
	logic                  el_we;
	logic [POS_BITS-1:0]   el_waddr, el_raddr0;
	logic [ELEM_BITS-1:0]  el_wdata;

	// pair addressing for the current layer
	assign narrow = layer_narrow(layer_q);
	assign lg     = layer_lg(layer_q);
	assign k      = pair_q[4:0];
	assign x      = pair_q[10:5];
	assign y0     = insert_zero(k, lg);
	assign y1     = y0 | (6'd1 << lg);

	always_comb begin
		if (narrow) begin
			addr_a    = {x, y0};
			addr_b    = {x, y1};
			cond_addr = {layer_q, x[5:1]};
			cbit      = {x[0], k};
		end else begin
			addr_a    = {y0, x};
			addr_b    = {y1, x};
			cond_addr = {layer_q, k};
			cbit      = x;
		end
	end

	assign swap = cond_rdata[cbit];

	always_comb begin
		el_we    = cmd.init_we || cmd.net_w1 || cmd.net_w2;
		el_waddr = init_cnt_q;
		el_wdata = rev12(init_cnt_q);
		if (cmd.net_w1) begin
			el_waddr = addr_a;
			el_wdata = swap ? rdata1 : rdata0;
		end else if (cmd.net_w2) begin
			el_waddr = addr_b;
			el_wdata = swap ? rdata0 : rdata1;
		end
	end

	assign el_raddr0 = cmd.rd_issue ? read_index : addr_a;

	bsg_ram #(.WIDTH(ELEM_BITS), .DEPTH(1 << POS_BITS)) u_elem_ram (
		.clk    (clk),
		.we     (el_we),
		.waddr  (el_waddr),
		.wdata  (el_wdata),
		.raddr0 (el_raddr0),
		.raddr1 (addr_b),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	bsg_ram #(.WIDTH(64), .DEPTH(COND_WORDS)) u_cond_ram (
		.clk    (clk),
		.we     (cmd.load_we),
		.waddr  (word_cnt_q),
		.wdata  (cond_word),
		.raddr0 (cond_addr),
		.raddr1 (cond_addr),
		.rdata0 (cond_rdata),
		.rdata1 ()
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_cnt_q  <= '0;
			word_cnt_q  <= '0;
			layer_q     <= '0;
			pair_q      <= '0;
			done_q      <= 1'b0;
			ok_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.init_we)
				init_cnt_q <= init_cnt_q + 1'b1;
			if (cmd.load_we)
				word_cnt_q <= word_cnt_q + 1'b1;
			if (cmd.net_w2) begin
				pair_q <= pair_q + 1'b1;
				if (&pair_q)
					layer_q <= layer_q + 1'b1;
			end
			if (cmd.set_done)
				done_q <= 1'b1;
			if (cmd.rd_issue)
				ok_s1 <= done_q && ({1'b0, read_index} < SUP_LIMIT);
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			elem_q <= ok_s1 ? rdata0 : '0;
			vres_q <= ok_s1;
		end
	end

	assign st.init_last  = &init_cnt_q;
	assign st.count_last = (word_cnt_q == CADDR_BITS'(COND_WORDS - 1));
	assign st.net_last   = (layer_q == 5'(LAYERS - 1)) && (&pair_q);
	assign st.done       = done_q;
	assign st.out_busy   = out_valid_q;

	assign out_valid    = out_valid_q;
	assign support_elem = elem_q;
	assign valid_res    = vres_q;
endmodule

FILE: test/tb_benes_support_generation.sv
`timescale 1ns / 1ps

module tb_benes_support_generation;
	import bsg_pkg::*;

	localparam int SUPPORT_CNT = 3488;
	localparam int POSITIONS   = 4096;
	localparam int CYCLE_LIMIT = 2000000;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_READ = 1'b1;

	// keeps its own copy of the element store and condition words, and the
	// queue of support reads that still owe a result
	class support_scoreboard;
		typedef struct {
			logic [ELEM_BITS-1:0] elem;
			logic                 vres;
		} support_read_t;

		support_read_t        pending_reads[$];
		logic [ELEM_BITS-1:0] elems[POSITIONS];
		logic [63:0]          words[COND_WORDS];
		int                   word_cnt;
		bit                   net_done;
		int                   errors;

		function new();
			for (int i = 0; i < POSITIONS; i++) begin
				for (int b = 0; b < ELEM_BITS; b++)
					elems[i][b] = i[ELEM_BITS-1-b];
			end
			word_cnt = 0;
			net_done = 0;
			errors   = 0;
		endfunction

		// swap rows and columns of the 64 x 64 position grid
		function void transpose_grid();
			logic [ELEM_BITS-1:0] t[POSITIONS];
			t = elems;
			for (int r = 0; r < 64; r++)
				for (int c = 0; c < 64; c++)
					elems[c*64+r] = t[r*64+c];
		endfunction

		// condition bit for row pair k, column b of layer t
		function bit cond_bit(int t, bit narrow, int k, int b);
			logic [63:0] w;
			if (narrow) begin
				w = words[(32*t + b/2) % COND_WORDS];
				return w[32*(b%2) + k];
			end
			w = words[(32*t + k) % COND_WORDS];
			return w[b];
		endfunction

		function void apply_layer(int t, bit narrow, int lg);
			int                   s;
			int                   k;
			logic [ELEM_BITS-1:0] x;
			s = 1 << lg;
			k = 0;
			for (int i = 0; i < 64; i += 2*s)
				for (int j = i; j < i + s; j++) begin
					for (int b = 0; b < 64; b++)
						if (cond_bit(t, narrow, k, b)) begin
							x                 = elems[j*64+b];
							elems[j*64+b]     = elems[(j+s)*64+b];
							elems[(j+s)*64+b] = x;
						end
					k++;
				end
		endfunction

		function void permute_support();
			int t;
			t = 0;
			transpose_grid();
			for (int lg = 0; lg <= 5; lg++) apply_layer(t++, 1, lg);
			transpose_grid();
			for (int lg = 0; lg <= 5; lg++) apply_layer(t++, 0, lg);
			for (int lg = 4; lg >= 0; lg--) apply_layer(t++, 0, lg);
			transpose_grid();
			for (int lg = 5; lg >= 0; lg--) apply_layer(t++, 1, lg);
			transpose_grid();
		endfunction

		// accepted input transaction
		function void note_input(logic mode, logic [63:0] word, logic [POS_BITS-1:0] idx);
			support_read_t r;
			if (mode == MODE_LOAD) begin
				if (!net_done && word_cnt < COND_WORDS) begin
					words[word_cnt] = word;
					word_cnt++;
					if (word_cnt == COND_WORDS) begin
						permute_support();
						net_done = 1;
					end
				end
				return;
			end
			if (net_done && idx < SUPPORT_CNT) begin
				r.elem = elems[idx];
				r.vres = 1'b1;
			end else begin
				r.elem = '0;
				r.vres = 1'b0;
			end
			pending_reads.push_back(r);
		endfunction

		// accepted result transaction
		function void check_result(logic [ELEM_BITS-1:0] elem, logic vres);
			support_read_t r;
			if (pending_reads.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: elem %0h valid_res %0b", elem, vres);
				return;
			end
			r = pending_reads.pop_front();
			if (elem !== r.elem || vres !== r.vres) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected elem %0h valid_res %0b, got elem %0h valid_res %0b",
						r.elem, r.vres, elem, vres);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bsg_in_if  in_ch();
	bsg_out_if out_ch();

	benes_support_generation #(.SUPPORT_COUNT(SUPPORT_CNT)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	support_scoreboard sb = new();
	bit idle_on;   // random idling on both sides
	int cycles = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// watchdog: ends the run with a failure once CYCLE_LIMIT is passed
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: check each accepted transaction, stall ready in bursts
	initial begin
		int stall_left;
		stall_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready)
				sb.check_result(out_ch.support_elem, out_ch.valid_res);
			if (stall_left == 0 && idle_on && $urandom_range(0, 11) == 0)
				stall_left = $urandom_range(1, 8);
			out_ch.ready <= arst_n && (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// one input transaction, with an optional idle burst in front of it
	task automatic send_item(logic mode, logic [63:0] word, logic [POS_BITS-1:0] idx);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.mode       <= mode;
		in_ch.cond_word  <= word;
		in_ch.read_index <= idx;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_input(mode, word, idx);
	endtask

	task automatic send_read(logic [POS_BITS-1:0] idx);
		send_item(MODE_READ, {$urandom, $urandom}, idx);
	endtask

	task automatic send_load(logic [63:0] word);
		send_item(MODE_LOAD, word, POS_BITS'($urandom));
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (sb.pending_reads.size() != 0) @(posedge clk);
	endtask

	// mostly reads inside the support, some anywhere
	function automatic logic [POS_BITS-1:0] pick_index();
		if ($urandom_range(0, 4) == 0)
			return POS_BITS'($urandom);
		return POS_BITS'($urandom_range(0, SUPPORT_CNT - 1));
	endfunction

	initial begin
		int loads;
		idle_on          = 1'b1;
		arst_n           = 1'b0;
		in_ch.valid      <= 1'b0;
		in_ch.mode       <= MODE_LOAD;
		in_ch.cond_word  <= '0;
		in_ch.read_index <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// early reads answer invalid, whatever the index
		send_read(0);
		send_read(SUPPORT_CNT - 1);
		send_read(SUPPORT_CNT);
		send_read(POSITIONS - 1);

		// condition words: extremes first, then random with early reads mixed in
		send_load('1);
		send_load('0);
		send_load(64'h5555_5555_5555_5555);
		send_load(64'hAAAA_AAAA_AAAA_AAAA);
		loads = 4;
		while (loads < COND_WORDS) begin
			idle_on = !(loads >= 300 && loads < 400);
			if ($urandom_range(0, 6) == 0)
				send_read(POS_BITS'($urandom));
			else begin
				send_load({$urandom, $urandom});
				loads++;
			end
		end

		// wait until every early read is back; the next read is taken only after the network has run
		wait_drained();

		// completed: support edges, then loads that must be dropped
		send_read(0);
		send_read(1);
		send_read(SUPPORT_CNT - 1);
		send_read(SUPPORT_CNT);
		send_read(POSITIONS - 1);
		send_load('1);
		send_load('0);
		send_read(0);

		for (int n = 0; n < 800; n++) begin
			idle_on = (n < 600);
			if ($urandom_range(0, 9) == 0)
				send_load({$urandom, $urandom});
			else
				send_read(pick_index());
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending_reads.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
